// ===== hw/rtl/sks_pkg.sv =====
// ----------------------------------------------------------------------------
// sks_pkg
// Shared types, codes and constants of the session keepalive supervisor.
// ----------------------------------------------------------------------------
package sks_pkg;

    localparam int unsigned TidW   = 31;
    localparam int unsigned TicksW = 16;
    localparam int unsigned LimitW = 8;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 16;

    localparam logic [TidW-1:0]   TID_SKIP    = {TidW{1'b1}};
    localparam logic [TidW-1:0]   TID_FIRST   = TidW'(1);
    localparam logic [TicksW-1:0] TICKS_RESET = TicksW'(100);
    localparam logic [LimitW-1:0] LIMIT_RESET = LimitW'(3);
    localparam logic [LimitW-1:0] CNT_MAX     = {LimitW{1'b1}};

    // event codes
    typedef enum logic [3:0] {
        REQ_CONNECT    = 4'd0,
        REQ_DISCONNECT = 4'd1,
        REQ_SESS_RESP  = 4'd2,
        REQ_SESS_RETRY = 4'd3,
        REQ_SESS_TMO   = 4'd4,
        REQ_KA_TICK    = 4'd5,
        REQ_KA_RESP    = 4'd6,
        REQ_KA_TMO     = 4'd7,
        REQ_RECONNECT  = 4'd8
    } req_t;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_RECONNECT_TICKS  = 3'd0,
        CFG_SESS_REPLY_TICKS = 3'd1,
        CFG_SESS_RETRY_LIMIT = 3'd2,
        CFG_KA_REPLY_TICKS   = 3'd3,
        CFG_KA_RETRY_LIMIT   = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MSG_NONE      = 2'd0,
        MSG_ESTABLISH = 2'd1,
        MSG_LINK_TEST = 2'd2
    } msg_t;

    typedef enum logic [1:0] {
        TMR_NONE      = 2'd0,
        TMR_SESS      = 2'd1,
        TMR_KA        = 2'd2,
        TMR_RECONNECT = 2'd3
    } tmr_t;

    // session state, one-hot
    typedef enum logic [5:0] {
        ST_DISC     = 6'b000001,
        ST_CONN     = 6'b000010,
        ST_SESS_REQ = 6'b000100,
        ST_SESS_RSP = 6'b001000,
        ST_KA_REQ   = 6'b010000,
        ST_KA_RSP   = 6'b100000
    } sess_state_t;

    localparam logic [2:0] CODE_DISC     = 3'd0;
    localparam logic [2:0] CODE_CONN     = 3'd1;
    localparam logic [2:0] CODE_SESS_REQ = 3'd2;
    localparam logic [2:0] CODE_SESS_RSP = 3'd3;
    localparam logic [2:0] CODE_KA_REQ   = 3'd4;
    localparam logic [2:0] CODE_KA_RSP   = 3'd5;

    typedef struct packed {
        logic [3:0] req_type;
        logic       conn_exists;
    } sks_item_t;

    typedef struct packed {
        logic [TicksW-1:0] reconnect_ticks;
        logic [TicksW-1:0] session_reply_ticks;
        logic [LimitW-1:0] session_retry_limit;
        logic [TicksW-1:0] keepalive_reply_ticks;
        logic [LimitW-1:0] keepalive_retry_limit;
    } sks_cfg_t;

    typedef struct packed {
        msg_t              send_msg;
        logic [TidW-1:0]   trans_id;
        tmr_t              timer_start;
        logic [TicksW-1:0] timer_ticks;
        logic              drop_conn;
        logic              open_conn;
        logic              link_up;
        logic [2:0]        session_state;
    } sks_result_t;

    function automatic logic [2:0] state_code(sess_state_t st);
        logic [2:0] code;
        case (st)
            ST_DISC:     code = CODE_DISC;
            ST_CONN:     code = CODE_CONN;
            ST_SESS_REQ: code = CODE_SESS_REQ;
            ST_SESS_RSP: code = CODE_SESS_RSP;
            ST_KA_REQ:   code = CODE_KA_REQ;
            ST_KA_RSP:   code = CODE_KA_RSP;
            default:     code = CODE_DISC;
        endcase
        return code;
    endfunction

endpackage

// ===== hw/rtl/sks_in_stage.sv =====
// ----------------------------------------------------------------------------
// sks_in_stage
// Input register of the supervisor with valid/stall handshake.
// ----------------------------------------------------------------------------
module sks_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  sks_pkg::sks_item_t in_item,
    input  logic              take,
    output logic              full,
    output sks_pkg::sks_item_t item
);
    import sks_pkg::*;

    logic      full_reg;
    logic      full_next;
    sks_item_t item_reg;
    logic      accept;

    // stage frees up in the same cycle its item moves on
    assign in_stall  = full_reg && !take;
    assign accept    = in_valid && !in_stall;
    assign full_next = accept || (full_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

    assign full = full_reg;
    assign item = item_reg;

endmodule

// ===== hw/rtl/sks_engine.sv =====
// ----------------------------------------------------------------------------
// sks_engine
// Session state, retry counters and ID generator; one event per cycle on upd.
// ----------------------------------------------------------------------------
module sks_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                upd,
    input  sks_pkg::sks_item_t  item,
    input  sks_pkg::sks_cfg_t   cfg,
    output sks_pkg::sks_result_t res
);
    import sks_pkg::*;

    sess_state_t       st_reg, st_next;
    logic [LimitW-1:0] sr_reg, sr_next;
    logic [LimitW-1:0] kr_reg, kr_next;
    logic [TidW-1:0]   tid_reg, tid_next;
    logic [TidW-1:0]   new_id;
    logic              do_est;
    logic              do_lt;
    sks_result_t       r;

    always_comb
    begin
        st_next  = st_reg;
        sr_next  = sr_reg;
        kr_next  = kr_reg;
        tid_next = tid_reg;
        r        = '0;
        do_est   = 1'b0;
        do_lt    = 1'b0;
        r.send_msg    = MSG_NONE;
        r.timer_start = TMR_NONE;
        new_id = (tid_reg == TID_SKIP || tid_reg == '0) ? TID_FIRST : tid_reg;

        case (item.req_type)
            REQ_CONNECT:
            begin
                do_est = 1'b1;
            end
            REQ_DISCONNECT:
            begin
                st_next       = ST_DISC;
                sr_next       = '0;
                kr_next       = '0;
                r.timer_start = TMR_RECONNECT;
                r.timer_ticks = cfg.reconnect_ticks;
            end
            REQ_SESS_RESP:
            begin
                if (st_reg == ST_SESS_REQ)
                begin
                    st_next   = ST_SESS_RSP;
                    r.link_up = 1'b1;
                    do_lt     = 1'b1;
                end
            end
            REQ_SESS_RETRY:
            begin
                if (st_reg inside {ST_CONN, ST_SESS_REQ})
                begin
                    if (cfg.session_retry_limit > sr_reg)
                    begin
                        // only the connected state actually sends
                        do_est = (st_reg == ST_CONN);
                    end
                    else
                    begin
                        r.drop_conn = 1'b1;
                    end
                end
            end
            REQ_SESS_TMO:
            begin
                r.drop_conn = (st_reg == ST_SESS_REQ) && item.conn_exists;
            end
            REQ_KA_TICK:
            begin
                do_lt = st_reg inside {ST_SESS_RSP, ST_KA_REQ, ST_KA_RSP};
            end
            REQ_KA_RESP:
            begin
                kr_next = '0;
                st_next = ST_KA_RSP;
            end
            REQ_KA_TMO:
            begin
                r.drop_conn = (st_reg == ST_KA_REQ) && item.conn_exists;
            end
            REQ_RECONNECT:
            begin
                r.open_conn = !item.conn_exists;
            end
            default:
            begin
            end
        endcase

        // establish request
        if (do_est)
        begin
            st_next       = ST_SESS_REQ;
            r.timer_start = TMR_SESS;
            r.timer_ticks = cfg.session_reply_ticks;
            sr_next       = (sr_reg == CNT_MAX) ? sr_reg : sr_reg + LimitW'(1);
            r.send_msg    = MSG_ESTABLISH;
            r.trans_id    = new_id;
            tid_next      = new_id + TidW'(1);
        end

        // link test request, or drop once the unanswered limit is hit
        if (do_lt)
        begin
            if (cfg.keepalive_retry_limit <= kr_reg)
            begin
                r.drop_conn = 1'b1;
            end
            else
            begin
                st_next       = ST_KA_REQ;
                r.timer_start = TMR_KA;
                r.timer_ticks = cfg.keepalive_reply_ticks;
                kr_next       = (kr_reg == CNT_MAX) ? kr_reg : kr_reg + LimitW'(1);
                r.send_msg    = MSG_LINK_TEST;
                r.trans_id    = new_id;
                tid_next      = new_id + TidW'(1);
            end
        end

        r.session_state = state_code(st_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_DISC;
            sr_reg  <= '0;
            kr_reg  <= '0;
            tid_reg <= TID_FIRST;
        end
        else if (upd)
        begin
            st_reg  <= st_next;
            sr_reg  <= sr_next;
            kr_reg  <= kr_next;
            tid_reg <= tid_next;
        end
    end

    assign res = r;

    // generator never holds zero
    a_tid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        tid_reg != '0)
        else $error("transaction id register is zero");

    // an ID is reported exactly when a request goes out
    a_id_with_msg: assert property (@(posedge clk) disable iff (!rst_n)
        (r.send_msg == MSG_NONE) == (r.trans_id == '0))
        else $error("trans_id and send_msg disagree");

    // link comes up only out of the session request state
    a_link_up_src: assert property (@(posedge clk) disable iff (!rst_n)
        r.link_up |-> st_reg == ST_SESS_REQ)
        else $error("link_up outside session request state");

    // a sent request moves the generator on by one
    a_tid_step: assert property (@(posedge clk) disable iff (!rst_n)
        upd && r.send_msg != MSG_NONE |=> tid_reg == $past(r.trans_id) + TidW'(1))
        else $error("transaction id did not advance");

endmodule

// ===== hw/rtl/session_keepalive_supervisor.sv =====
// ----------------------------------------------------------------------------
// session_keepalive_supervisor
// Link session supervisor: one event in, one action item out.
// ----------------------------------------------------------------------------
// Takes one event item per cycle while in_stall is low and returns exactly
// one result item per event, in order. An event passes an input register,
// then the state logic updates session state, retry counters and the
// transaction ID generator and writes the result into the output register,
// which raises out_valid; one event per cycle is sustained while out_stall is
// low. The input stage keeps accepting while a result waits on out_stall,
// until both registers are full.
// Configuration registers (reconnect_ticks, session_reply_ticks,
// session_retry_limit, keepalive_reply_ticks, keepalive_retry_limit) are
// written through cfg_we/cfg_index/cfg_data and should only change while no
// event is in flight. Unknown event codes report the unchanged state only.
// ----------------------------------------------------------------------------
module session_keepalive_supervisor (
    input  logic        clk,
    input  logic        rst_n,
    // event channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  req_type,
    input  logic        conn_exists,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  send_msg,
    output logic [30:0] trans_id,
    output logic [1:0]  timer_start,
    output logic [15:0] timer_ticks,
    output logic        drop_conn,
    output logic        open_conn,
    output logic        link_up,
    output logic [2:0]  session_state,
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import sks_pkg::*;

    sks_item_t   in_item;
    sks_item_t   stage_item;
    logic        stage_full;
    logic        adv;
    sks_cfg_t    cfg_reg;
    sks_result_t res;
    sks_result_t out_reg;
    logic        out_valid_reg;
    logic        out_valid_next;

    assign in_item.req_type    = req_type;
    assign in_item.conn_exists = conn_exists;

    // event moves into the output register whenever that slot is free
    assign adv = stage_full && (!out_valid_reg || !out_stall);

    sks_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .take     (adv),
        .full     (stage_full),
        .item     (stage_item)
    );

    sks_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (adv),
        .item  (stage_item),
        .cfg   (cfg_reg),
        .res   (res)
    );

    // configuration registers; indexes past the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reconnect_ticks       <= TICKS_RESET;
            cfg_reg.session_reply_ticks   <= TICKS_RESET;
            cfg_reg.session_retry_limit   <= LIMIT_RESET;
            cfg_reg.keepalive_reply_ticks <= TICKS_RESET;
            cfg_reg.keepalive_retry_limit <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RECONNECT_TICKS:  cfg_reg.reconnect_ticks       <= cfg_data;
                CFG_SESS_REPLY_TICKS: cfg_reg.session_reply_ticks   <= cfg_data;
                CFG_SESS_RETRY_LIMIT: cfg_reg.session_retry_limit   <= cfg_data[LimitW-1:0];
                CFG_KA_REPLY_TICKS:   cfg_reg.keepalive_reply_ticks <= cfg_data;
                CFG_KA_RETRY_LIMIT:   cfg_reg.keepalive_retry_limit <= cfg_data[LimitW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // output register: loads on adv, empties when taken
    assign out_valid_next = adv || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign send_msg      = out_reg.send_msg;
    assign trans_id      = out_reg.trans_id;
    assign timer_start   = out_reg.timer_start;
    assign timer_ticks   = out_reg.timer_ticks;
    assign drop_conn     = out_reg.drop_conn;
    assign open_conn     = out_reg.open_conn;
    assign link_up       = out_reg.link_up;
    assign session_state = out_reg.session_state;

endmodule
